FILE: sv/slrf_pkg.sv
// Shared types, register indexes and the seven-segment table for the LCD formatter.
package slrf_pkg;

   typedef logic [7:0] seg_byte_type;

   typedef enum logic {
      CSR_BLINK_SHOW_LENGTH = 1'b0,
      CSR_BLINK_WRAP_VALUE  = 1'b1
   } csr_index_type;

   localparam logic [3:0] BLINK_SHOW_RESET = 4'd5;
   localparam logic [3:0] BLINK_WRAP_RESET = 4'd10;

   localparam logic [1:0] DIGIT_THOUSANDS = 2'd0;
   localparam logic [1:0] DIGIT_HUNDREDS  = 2'd1;
   localparam logic [1:0] DIGIT_TENS      = 2'd2;

   localparam logic [3:0] CHANNEL_MIN     = 4'd1;
   localparam logic [3:0] CHANNEL_MAX     = 4'd8;
   localparam logic [3:0] CHANNEL_MA      = 4'd1;
   localparam logic [3:0] CHANNEL_CELSIUS_LAST = 4'd5;

   localparam logic [7:0] ICON_MA         = 8'h04;
   localparam logic [7:0] ICON_LIVE       = 8'h30;
   localparam logic [7:0] ICON_THRESHOLD  = 8'h20;
   localparam logic [7:0] ICON_AMP        = 8'h40;
   localparam logic [7:0] ICON_CELSIUS    = 8'h80;
   localparam logic [7:0] ICON_DP         = 8'h80;
   localparam logic [7:0] ICON_SETTING    = 8'h02;

   localparam logic OP_LIVE      = 1'b0;
   localparam logic OP_THRESHOLD = 1'b1;

   function automatic seg_byte_type seg_code(input logic [3:0] digit);
      seg_byte_type code;
      case (digit)
         4'd0: code = 8'h77;
         4'd1: code = 8'h14;
         4'd2: code = 8'h5b;
         4'd3: code = 8'h5d;
         4'd4: code = 8'h3c;
         4'd5: code = 8'h6d;
         4'd6: code = 8'h6f;
         4'd7: code = 8'h54;
         4'd8: code = 8'h7f;
         4'd9: code = 8'h7d;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

FILE: sv/slrf_if.sv
// Request and response channel interfaces of the LCD formatter.
interface slrf_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [3:0]  channel;
   logic [15:0] reading;
   logic [1:0]  blink_digit;

   modport source(output valid, op, channel, reading, blink_digit, input ready);
   modport sink(input valid, op, channel, reading, blink_digit, output ready);
endinterface

interface slrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ram_byte_0;
   logic [7:0] ram_byte_1;
   logic [7:0] ram_byte_3;
   logic [7:0] ram_byte_4;
   logic [7:0] ram_byte_7;
   logic [7:0] ram_byte_8;
   logic [7:0] ram_byte_10;
   logic [7:0] ram_byte_11;
   logic [7:0] ram_byte_12;

   modport source(output valid, ram_byte_0, ram_byte_1, ram_byte_3, ram_byte_4,
                  ram_byte_7, ram_byte_8, ram_byte_10, ram_byte_11, ram_byte_12,
                  input ready);
   modport sink(input valid, ram_byte_0, ram_byte_1, ram_byte_3, ram_byte_4,
                ram_byte_7, ram_byte_8, ram_byte_10, ram_byte_11, ram_byte_12,
                output ready);
endinterface

FILE: sv/segment_lcd_reading_formatter.sv
// An accepted request's response becomes valid on rsp_if once it reaches the response register.
// Throughput: one request per cycle; four register stages (input register,
// mod-1000 split, hundreds split, response register after the tens split and
// segment scatter) advance independently, so requests are held off only while
// all four stages are full and the response waits.
// Reset (synchronous, active high) empties the pipeline, clears the blink
// counter and loads the blink registers with 5 and 10.
module segment_lcd_reading_formatter
   import slrf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   slrf_req_if.sink        req_if,
   slrf_rsp_if.source      rsp_if,
   input  logic            csr_write,
   input  csr_index_type   csr_index,
   input  logic [3:0]      csr_wdata
);

   // control state
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       v1_in, v2_in, v3_in, v4_in;
   logic [3:0] show_ff, show_in;
   logic [3:0] wrap_ff, wrap_in;
   logic [3:0] count_ff, count_in;
   logic       can1, can2, can3, can4;
   logic       req_fire;

   // stage 1: registered request
   logic        op1_ff;
   logic [3:0]  ch1_ff;
   logic [15:0] rd1_ff;
   logic [1:0]  bd1_ff;
   logic        blank1_ff, blank1_in;

   // stage 2: leading digit and value mod 1000
   logic        op2_ff;
   logic [3:0]  ch2_ff;
   logic [3:0]  d4_2_ff;
   logic [9:0]  low2_ff;
   logic [1:0]  bd2_ff;
   logic        blank2_ff;

   // stage 3: hundreds digit and remainder
   logic        op3_ff;
   logic [3:0]  ch3_ff;
   logic [3:0]  d4_3_ff;
   logic [3:0]  d3_3_ff;
   logic [6:0]  rem3_ff;
   logic [1:0]  bd3_ff;
   logic        blank3_ff;

   // stage 4: response register
   seg_byte_type b0_ff, b1_ff, b3_ff, b4_ff, b7_ff, b8_ff, b10_ff, b11_ff, b12_ff;
   seg_byte_type b0_in, b1_in, b3_in, b4_in, b7_in, b8_in, b10_in, b11_in, b12_in;

   // mod-1000 datapath
   logic [26:0] q_prod;
   logic [6:0]  q1000;
   logic [15:0] q_times;
   logic [15:0] low_full;
   logic        ch_ok;
   logic [9:0]  low2_in;
   logic [3:0]  d4_2_in;

   // hundreds datapath
   logic [15:0] h_prod;
   logic [3:0]  d3_in;
   logic [9:0]  h_times;
   logic [9:0]  rem_full;

   // tens datapath
   logic [14:0] t_prod;
   logic [3:0]  d2;
   logic [6:0]  t_times;
   logic [6:0]  u_full;
   logic [3:0]  d1;
   seg_byte_type c4, c3, c2, c1;

   assign can4     = !v4_ff || rsp_if.ready;
   assign can3     = !v3_ff || can4;
   assign can2     = !v2_ff || can3;
   assign can1     = !v1_ff || can2;
   assign req_fire = req_if.valid && can1;

   assign req_if.ready = can1;

   // blink decision is made at accept time, in request order
   always_comb begin
      count_in  = count_ff;
      blank1_in = 1'b0;
      if (req_fire && req_if.op == OP_THRESHOLD) begin
         blank1_in = (count_ff >= show_ff);
         if (count_ff < wrap_ff) begin
            count_in = count_ff + 4'd1;
         end else begin
            count_in = 4'd0;
         end
      end
   end

   always_comb begin
      show_in = show_ff;
      wrap_in = wrap_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BLINK_SHOW_LENGTH: show_in = csr_wdata;
            CSR_BLINK_WRAP_VALUE:  wrap_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      v1_in = can1 ? req_if.valid : v1_ff;
      v2_in = can2 ? v1_ff : v2_ff;
      v3_in = can3 ? v2_ff : v3_ff;
      v4_in = can4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         show_ff  <= BLINK_SHOW_RESET;
         wrap_ff  <= BLINK_WRAP_RESET;
         count_ff <= 4'd0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         show_ff  <= show_in;
         wrap_ff  <= wrap_in;
         count_ff <= count_in;
      end
   end

   // x / 1000 = (x >> 3) / 125, reciprocal 8389 / 2^20 is exact over 16 bits
   assign ch_ok    = (ch1_ff >= CHANNEL_MIN) && (ch1_ff <= CHANNEL_MAX);
   assign q_prod   = 27'(rd1_ff[15:3]) * 27'd8389;
   assign q1000    = q_prod[26:20];
   assign q_times  = 16'(q1000) * 16'd1000;
   assign low_full = rd1_ff - q_times;
   assign low2_in  = ch_ok ? low_full[9:0] : 10'd0;
   assign d4_2_in  = ch_ok ? ch1_ff : 4'd0;

   // n / 100 = (n * 41) >> 12 for n < 1000
   assign h_prod   = 16'(low2_ff) * 16'd41;
   assign d3_in    = h_prod[15:12];
   assign h_times  = 10'(d3_in) * 10'd100;
   assign rem_full = low2_ff - h_times;

   // n / 10 = (n * 205) >> 11 for n < 100
   assign t_prod  = 15'(rem3_ff) * 15'd205;
   assign d2      = t_prod[14:11];
   assign t_times = 7'(d2) * 7'd10;
   assign u_full  = rem3_ff - t_times;
   assign d1      = u_full[3:0];

   always_comb begin
      c4 = seg_code(d4_3_ff);
      c3 = seg_code(d3_3_ff);
      c2 = seg_code(d2);
      c1 = seg_code(d1);
      if (blank3_ff) begin
         case (bd3_ff)
            DIGIT_THOUSANDS: c4 = 8'h00;
            DIGIT_HUNDREDS:  c3 = 8'h00;
            DIGIT_TENS:      c2 = 8'h00;
            default:         c1 = 8'h00;
         endcase
      end

      b0_in  = ((c4 & 8'h60) >> 3) | ((c3 & 8'h60) >> 1) | ((c2 & 8'h60) << 1);
      b1_in  = (c1 & 8'h60) >> 5;
      b3_in  = (c4 & 8'h18) << 3;
      b4_in  = ((c3 & 8'h18) >> 3) | ((c2 & 8'h18) >> 1) | ((c1 & 8'h18) << 1);
      b7_in  = ((c4 & 8'h06) << 1) | ((c3 & 8'h06) << 3) | ((c2 & 8'h06) << 5);
      b8_in  = (c1 & 8'h06) >> 1;
      b10_in = ((c4 & 8'h01) << 6) | ICON_DP;
      b11_in = (c3 & 8'h01) | ((c2 & 8'h01) << 2) | ((c1 & 8'h01) << 4);
      b12_in = 8'h00;

      // unit icon by channel; out-of-range channels get none
      if (ch3_ff == CHANNEL_MA) begin
         b1_in = b1_in | ICON_MA;
         b4_in = b4_in | ICON_AMP;
      end else if (ch3_ff > CHANNEL_MA && ch3_ff <= CHANNEL_CELSIUS_LAST) begin
         b4_in = b4_in | ICON_CELSIUS;
      end else if (ch3_ff > CHANNEL_CELSIUS_LAST && ch3_ff <= CHANNEL_MAX) begin
         b4_in = b4_in | ICON_AMP;
      end

      if (op3_ff == OP_THRESHOLD) begin
         b3_in  = b3_in | ICON_THRESHOLD;
         b12_in = ICON_SETTING;
      end else begin
         b1_in = b1_in | ICON_LIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (can1) begin
         op1_ff    <= req_if.op;
         ch1_ff    <= req_if.channel;
         rd1_ff    <= req_if.reading;
         bd1_ff    <= req_if.blink_digit;
         blank1_ff <= blank1_in;
      end
      if (can2) begin
         op2_ff    <= op1_ff;
         ch2_ff    <= ch1_ff;
         d4_2_ff   <= d4_2_in;
         low2_ff   <= low2_in;
         bd2_ff    <= bd1_ff;
         blank2_ff <= blank1_ff;
      end
      if (can3) begin
         op3_ff    <= op2_ff;
         ch3_ff    <= ch2_ff;
         d4_3_ff   <= d4_2_ff;
         d3_3_ff   <= d3_in;
         rem3_ff   <= rem_full[6:0];
         bd3_ff    <= bd2_ff;
         blank3_ff <= blank2_ff;
      end
      if (can4) begin
         b0_ff  <= b0_in;
         b1_ff  <= b1_in;
         b3_ff  <= b3_in;
         b4_ff  <= b4_in;
         b7_ff  <= b7_in;
         b8_ff  <= b8_in;
         b10_ff <= b10_in;
         b11_ff <= b11_in;
         b12_ff <= b12_in;
      end
   end

   assign rsp_if.valid       = v4_ff;
   assign rsp_if.ram_byte_0  = b0_ff;
   assign rsp_if.ram_byte_1  = b1_ff;
   assign rsp_if.ram_byte_3  = b3_ff;
   assign rsp_if.ram_byte_4  = b4_ff;
   assign rsp_if.ram_byte_7  = b7_ff;
   assign rsp_if.ram_byte_8  = b8_ff;
   assign rsp_if.ram_byte_10 = b10_ff;
   assign rsp_if.ram_byte_11 = b11_ff;
   assign rsp_if.ram_byte_12 = b12_ff;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the segment LCD reading formatter.
module testbench;
   import slrf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 8;
   localparam int PIPE_LATENCY = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [1:0] DIGIT_UNITS = 2'd3;

   localparam seg_byte_type SEG_TABLE [0:9] = '{
      8'h77, 8'h14, 8'h5b, 8'h5d, 8'h3c, 8'h6d, 8'h6f, 8'h54, 8'h7f, 8'h7d
   };

   typedef struct packed {
      logic        op;
      logic [3:0]  channel;
      logic [15:0] reading;
      logic [1:0]  blink_digit;
   } lcd_request_type;

   typedef struct packed {
      seg_byte_type b0;
      seg_byte_type b1;
      seg_byte_type b3;
      seg_byte_type b4;
      seg_byte_type b7;
      seg_byte_type b8;
      seg_byte_type b10;
      seg_byte_type b11;
      seg_byte_type b12;
   } lcd_ram_type;

   logic          clock;
   logic          reset;
   logic          csr_write;
   csr_index_type csr_index;
   logic [3:0]    csr_wdata;

   slrf_req_if req_ch();
   slrf_rsp_if rsp_ch();

   segment_lcd_reading_formatter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state, mirrors the block's registers and blink counter
   logic [3:0] show_len;
   logic [3:0] wrap_val;
   logic [3:0] blink_phase;

   lcd_ram_type expected_ram_q[$];
   int          mismatch_count;
   int          cycle_count;
   int          burst_left;
   bit          tx_idle_en;
   bit          rx_stall_en;

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d responses outstanding", $time, expected_ram_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // expected RAM image for one request; advances the blink counter on threshold requests
   function automatic lcd_ram_type format_lcd_ram(input lcd_request_type r);
      logic [9:0]   low;
      logic [3:0]   lead;
      logic [3:0]   d3, d2, d1;
      seg_byte_type c4, c3, c2, c1;
      lcd_ram_type  e;
      low  = '0;
      lead = '0;
      if (r.channel >= CHANNEL_MIN && r.channel <= CHANNEL_MAX) begin
         low  = 10'(r.reading % 1000);
         lead = r.channel;
      end
      d3 = 4'(low / 100);
      d2 = 4'((low / 10) % 10);
      d1 = 4'(low % 10);
      c4 = SEG_TABLE[lead];
      c3 = SEG_TABLE[d3];
      c2 = SEG_TABLE[d2];
      c1 = SEG_TABLE[d1];
      if (r.op == OP_THRESHOLD) begin
         if (blink_phase >= show_len) begin
            case (r.blink_digit)
               DIGIT_THOUSANDS: c4 = '0;
               DIGIT_HUNDREDS:  c3 = '0;
               DIGIT_TENS:      c2 = '0;
               default:         c1 = '0;
            endcase
         end
         if (blink_phase < wrap_val) blink_phase = blink_phase + 4'd1;
         else blink_phase = '0;
      end
      e.b0  = ((c4 & 8'h60) >> 3) | ((c3 & 8'h60) >> 1) | ((c2 & 8'h60) << 1);
      e.b1  = (c1 & 8'h60) >> 5;
      e.b3  = (c4 & 8'h18) << 3;
      e.b4  = ((c3 & 8'h18) >> 3) | ((c2 & 8'h18) >> 1) | ((c1 & 8'h18) << 1);
      e.b7  = ((c4 & 8'h06) << 1) | ((c3 & 8'h06) << 3) | ((c2 & 8'h06) << 5);
      e.b8  = (c1 & 8'h06) >> 1;
      e.b10 = ((c4 & 8'h01) << 6) | ICON_DP;
      e.b11 = (c3 & 8'h01) | ((c2 & 8'h01) << 2) | ((c1 & 8'h01) << 4);
      e.b12 = '0;
      if (r.channel == CHANNEL_MA) begin
         e.b1 |= ICON_MA;
         e.b4 |= ICON_AMP;
      end else if (r.channel > CHANNEL_MA && r.channel <= CHANNEL_CELSIUS_LAST) begin
         e.b4 |= ICON_CELSIUS;
      end else if (r.channel > CHANNEL_CELSIUS_LAST && r.channel <= CHANNEL_MAX) begin
         e.b4 |= ICON_AMP;
      end
      if (r.op == OP_THRESHOLD) begin
         e.b3  |= ICON_THRESHOLD;
         e.b12 = ICON_SETTING;
      end else begin
         e.b1 |= ICON_LIVE;
      end
      return e;
   endfunction

   function automatic lcd_request_type make_request(input logic op, input logic [3:0] channel,
                                                     input logic [15:0] reading,
                                                     input logic [1:0] blink_digit);
      lcd_request_type r;
      r.op          = op;
      r.channel     = channel;
      r.reading     = reading;
      r.blink_digit = blink_digit;
      return r;
   endfunction

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      r.op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) r.channel = 4'($urandom_range(0, 15));
      else r.channel = 4'($urandom_range(CHANNEL_MIN, CHANNEL_MAX));
      case ($urandom_range(0, 9))
         0:       r.reading = 16'hffff;
         1:       r.reading = 16'($urandom_range(0, 64) * 1000 + $urandom_range(990, 999));
         2:       r.reading = 16'($urandom_range(0, 64) * 1000 + $urandom_range(0, 9));
         default: r.reading = 16'($urandom);
      endcase
      r.blink_digit = 2'($urandom_range(0, 3));
      return r;
   endfunction

   task automatic send_request(input lcd_request_type r);
      if (tx_idle_en && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.op          <= r.op;
      req_ch.channel     <= r.channel;
      req_ch.reading     <= r.reading;
      req_ch.blink_digit <= r.blink_digit;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_ram_q.push_back(format_lcd_ram(r));
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_ram_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // only called with the pipeline empty
   task automatic write_csr(input csr_index_type idx, input logic [3:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_BLINK_SHOW_LENGTH: show_len = value;
         CSR_BLINK_WRAP_VALUE:  wrap_val = value;
         default: ;
      endcase
   endtask

   task automatic set_blink(input logic [3:0] show, input logic [3:0] wrap);
      wait_for_idle();
      write_csr(CSR_BLINK_SHOW_LENGTH, show);
      write_csr(CSR_BLINK_WRAP_VALUE, wrap);
   endtask

   // field extremes, all digits, unit icons, bad channels and a full blink period
   task automatic test_directed_fields();
      send_request(make_request(OP_LIVE, 4'd1, 16'd0, 2'd0));
      send_request(make_request(OP_LIVE, 4'd1, 16'd999, 2'd3));
      send_request(make_request(OP_LIVE, 4'd2, 16'd1000, 2'd1));
      send_request(make_request(OP_LIVE, 4'd5, 16'hffff, 2'd2));
      send_request(make_request(OP_LIVE, 4'd6, 16'd12345, 2'd0));
      send_request(make_request(OP_LIVE, 4'd8, 16'd678, 2'd3));
      send_request(make_request(OP_LIVE, 4'd3, 16'd456, 2'd1));
      send_request(make_request(OP_LIVE, 4'd0, 16'd777, 2'd0));
      send_request(make_request(OP_LIVE, 4'd9, 16'd123, 2'd2));
      send_request(make_request(OP_LIVE, 4'd15, 16'hffff, 2'd3));
      send_request(make_request(OP_THRESHOLD, 4'd0, 16'd888, 2'd0));
      for (int i = 0; i < 12; i++)
         send_request(make_request(OP_THRESHOLD, 4'd4, 16'd321, i[1:0]));
      wait_for_idle();
   endtask

   task automatic test_blink_registers();
      // blank on every threshold request; live requests leave the counter alone
      set_blink(4'd0, 4'd15);
      for (int i = 0; i < 6; i++)
         send_request(make_request(i[0] ? OP_LIVE : OP_THRESHOLD, 4'd7, 16'd909, i[1:0]));
      // widest period: blanked only at the top count
      set_blink(4'd15, 4'd15);
      for (int i = 0; i < 20; i++)
         send_request(make_request(OP_THRESHOLD, 4'd2, 16'd135, DIGIT_UNITS));
      // counter left above a newly lowered wrap value returns to zero
      set_blink(4'd8, 4'd15);
      for (int i = 0; i < 10; i++)
         send_request(make_request(OP_THRESHOLD, 4'd6, 16'd246, DIGIT_TENS));
      set_blink(4'd1, 4'd2);
      for (int i = 0; i < 6; i++)
         send_request(make_request(OP_THRESHOLD, 4'd1, 16'd579, i[1:0]));
      // counter pinned at zero
      set_blink(4'd0, 4'd0);
      for (int i = 0; i < 4; i++)
         send_request(make_request(OP_THRESHOLD, 4'd8, 16'd680, i[1:0]));
      set_blink(BLINK_SHOW_RESET, BLINK_WRAP_RESET);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       set_blink(4'd0, 4'd0);
            1:       set_blink(4'd15, 4'd15);
            2:       set_blink(4'd15, 4'd0);
            3:       set_blink(4'd0, 4'd15);
            default: set_blink(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         endcase
         // one phase runs back to back on both sides
         tx_idle_en  = (phase != 4);
         rx_stall_en = (phase != 4);
         for (int i = 0; i < 100; i++) send_request(random_request());
      end
      tx_idle_en  = 1'b1;
      rx_stall_en = 1'b1;
   endtask

   // response checker
   task automatic check_byte(input string field, input seg_byte_type want,
                             input seg_byte_type got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t %s expected %02h actual %02h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      lcd_ram_type e;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_ram_q.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected response", $time);
         end else begin
            e = expected_ram_q.pop_front();
            check_byte("ram_byte_0", e.b0, rsp_ch.ram_byte_0);
            check_byte("ram_byte_1", e.b1, rsp_ch.ram_byte_1);
            check_byte("ram_byte_3", e.b3, rsp_ch.ram_byte_3);
            check_byte("ram_byte_4", e.b4, rsp_ch.ram_byte_4);
            check_byte("ram_byte_7", e.b7, rsp_ch.ram_byte_7);
            check_byte("ram_byte_8", e.b8, rsp_ch.ram_byte_8);
            check_byte("ram_byte_10", e.b10, rsp_ch.ram_byte_10);
            check_byte("ram_byte_11", e.b11, rsp_ch.ram_byte_11);
            check_byte("ram_byte_12", e.b12, rsp_ch.ram_byte_12);
         end
      end
   end

   // receiver stalls from a random bit pattern, sometimes all ready
   initial begin
      logic [15:0] stall_bits;
      logic [3:0]  stall_slot;
      stall_bits   = '1;
      stall_slot   = '0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_slot == 0)
            stall_bits = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
         rsp_ch.ready <= !rx_stall_en || stall_bits[stall_slot];
         stall_slot++;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.op          = OP_LIVE;
      req_ch.channel     = '0;
      req_ch.reading     = '0;
      req_ch.blink_digit = '0;
      csr_write          = 1'b0;
      csr_index          = CSR_BLINK_SHOW_LENGTH;
      csr_wdata          = '0;
      show_len           = BLINK_SHOW_RESET;
      wrap_val           = BLINK_WRAP_RESET;
      blink_phase        = '0;
      mismatch_count     = 0;
      cycle_count        = 0;
      burst_left         = 0;
      tx_idle_en         = 1'b1;
      rx_stall_en        = 1'b1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_directed_fields();
      test_blink_registers();
      test_random_traffic();
      wait_for_idle();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
